>>> rtl/sgen_pkg.sv
// ----------------------------------------------------------------------------
// sgen_pkg
// Shared types, constants and the cosine table builder for the two-channel
// sine sample generator.
// ----------------------------------------------------------------------------
package sgen_pkg;

	// window and table geometry (both powers of two)
	localparam int WINDOW_DEPTH      = 1024;
	localparam int WIN_AW            = $clog2(WINDOW_DEPTH);
	localparam int FILL_W            = WIN_AW + 1;
	localparam int COS_TABLE_ENTRIES = 1024;
	localparam int COS_AW            = $clog2(COS_TABLE_ENTRIES);

	localparam int RIDX_W = 10;
	localparam int SUM_W  = ((WIN_AW > RIDX_W) ? WIN_AW : RIDX_W) + 1;

	// arithmetic widths
	localparam int RMS_W  = 26;
	localparam int SQ_W   = 31;
	localparam int PP_W   = RMS_W + SQ_W;
	localparam int AMP_W  = 27;
	localparam int MAG_W  = 31;
	localparam int PROD_W = AMP_W + MAG_W;
	localparam int TICK_W = 8;
	localparam int DIV_W  = 9;
	localparam int DIV_MAX = 256;

	localparam logic [SQ_W-1:0] SQRT2_Q30 = 31'd1518500250;

	// configuration port
	localparam int ADDR_W = 5;
	localparam logic [2:0] REG_PHASE_STEP   = 3'd0;
	localparam logic [2:0] REG_PHASE_OFFSET = 3'd1;
	localparam logic [2:0] REG_VOLTAGE_RMS  = 3'd2;
	localparam logic [2:0] REG_CURRENT_RMS  = 3'd3;
	localparam logic [2:0] REG_TICK_DIVIDE  = 3'd4;
	localparam logic [DIV_W-1:0] TICK_DIVIDE_RST = 9'd11;

	// item codes
	localparam logic OP_TICK     = 1'b0;
	localparam logic OP_READ     = 1'b1;
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_READ   = 1'b1;

	typedef struct packed {
		logic              opcode;
		logic [RIDX_W-1:0] read_index;
	} req_t;

	typedef struct packed {
		logic               result_kind;
		logic signed [31:0] voltage_sample;
		logic signed [31:0] current_sample;
	} rsp_t;

	typedef struct packed {
		logic [31:0]      phase_step;
		logic [15:0]      phase_offset;
		logic [AMP_W-1:0] voltage_amp;
		logic [AMP_W-1:0] current_amp;
		logic [DIV_W-1:0] tick_divide;
	} cfg_t;

	typedef struct packed {
		logic [31:0] voltage;
		logic [31:0] current;
	} win_word_t;

	typedef logic signed [31:0] cos_rom_t [COS_TABLE_ENTRIES];

	// fixed-point cosine, elaboration only
	localparam logic [63:0] Q30_ONE    = 64'd1073741824;
	localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

	function automatic logic [63:0] poly_cos(input logic [63:0] f);
		logic [63:0] r;
		logic [63:0] s;
		logic [63:0] t;
		r = (f * TWO_PI_Q30) >> 32;
		s = (r * r) >> 30;
		t = Q30_ONE - s / 90;
		t = Q30_ONE - ((s * t) >> 30) / 56;
		t = Q30_ONE - ((s * t) >> 30) / 30;
		t = Q30_ONE - ((s * t) >> 30) / 12;
		t = Q30_ONE - ((s * t) >> 30) / 2;
		return t;
	endfunction

	function automatic logic [63:0] poly_sin(input logic [63:0] f);
		logic [63:0] r;
		logic [63:0] s;
		logic [63:0] t;
		r = (f * TWO_PI_Q30) >> 32;
		s = (r * r) >> 30;
		t = Q30_ONE - s / 110;
		t = Q30_ONE - ((s * t) >> 30) / 72;
		t = Q30_ONE - ((s * t) >> 30) / 42;
		t = Q30_ONE - ((s * t) >> 30) / 20;
		t = Q30_ONE - ((s * t) >> 30) / 6;
		return (r * t) >> 30;
	endfunction

	function automatic logic [63:0] quarter_cos(input logic [63:0] f);
		return (f <= 64'd536870912) ? poly_cos(f) : poly_sin(64'd1073741824 - f);
	endfunction

	function automatic logic [63:0] quarter_sin(input logic [63:0] f);
		return (f <= 64'd536870912) ? poly_sin(f) : poly_cos(64'd1073741824 - f);
	endfunction

	function automatic logic signed [31:0] full_cos(input logic [31:0] ph);
		logic [63:0] f;
		logic [63:0] v;
		logic        neg;
		f = {34'd0, ph[29:0]};
		case (ph[31:30])
			2'd0: begin
				v = quarter_cos(f);
				neg = 1'b0;
			end
			2'd1: begin
				v = quarter_sin(f);
				neg = 1'b1;
			end
			2'd2: begin
				v = quarter_cos(f);
				neg = 1'b1;
			end
			default: begin
				v = quarter_sin(f);
				neg = 1'b0;
			end
		endcase
		return neg ? -$signed(v[31:0]) : $signed(v[31:0]);
	endfunction

	function automatic cos_rom_t build_cos_rom();
		cos_rom_t    rom;
		logic [31:0] ph;
		for (int k = 0; k < COS_TABLE_ENTRIES; k++) begin
			ph = 32'(k) << (32 - COS_AW);
			rom[k] = full_cos(ph);
		end
		return rom;
	endfunction

endpackage

>>> rtl/sgen_regs.sv
// ----------------------------------------------------------------------------
// sgen_regs
// Configuration registers on the APB port, with the RMS to peak amplitude
// scaling kept up to date behind them.
// ----------------------------------------------------------------------------
module sgen_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sgen_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output sgen_pkg::cfg_t                cfg
);

	logic [31:0]                   phase_step_q;
	logic [15:0]                   phase_offset_q;
	logic [sgen_pkg::RMS_W-1:0]    voltage_rms_q;
	logic [sgen_pkg::RMS_W-1:0]    current_rms_q;
	logic [sgen_pkg::DIV_W-1:0]    tick_divide_q;
	logic [sgen_pkg::PP_W-1:0]     pp_v_q;
	logic [sgen_pkg::PP_W-1:0]     pp_c_q;
	logic [sgen_pkg::AMP_W-1:0]    amp_v_q;
	logic [sgen_pkg::AMP_W-1:0]    amp_c_q;
	logic [2:0]                    reg_idx;
	logic                          wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q   <= '0;
			phase_offset_q <= '0;
			voltage_rms_q  <= '0;
			current_rms_q  <= '0;
			tick_divide_q  <= sgen_pkg::TICK_DIVIDE_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				sgen_pkg::REG_PHASE_STEP:   phase_step_q   <= pwdata;
				sgen_pkg::REG_PHASE_OFFSET: phase_offset_q <= pwdata[15:0];
				sgen_pkg::REG_VOLTAGE_RMS:  voltage_rms_q  <= pwdata[sgen_pkg::RMS_W-1:0];
				sgen_pkg::REG_CURRENT_RMS:  current_rms_q  <= pwdata[sgen_pkg::RMS_W-1:0];
				sgen_pkg::REG_TICK_DIVIDE:  tick_divide_q  <= pwdata[sgen_pkg::DIV_W-1:0];
				default: ;
			endcase
		end
	end

	// amp = round(rms * sqrt2), registered through pp_*_q and then amp_*_q after a write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pp_v_q  <= '0;
			pp_c_q  <= '0;
			amp_v_q <= '0;
			amp_c_q <= '0;
		end else begin
			pp_v_q  <= sgen_pkg::PP_W'(voltage_rms_q) * sgen_pkg::PP_W'(sgen_pkg::SQRT2_Q30);
			pp_c_q  <= sgen_pkg::PP_W'(current_rms_q) * sgen_pkg::PP_W'(sgen_pkg::SQRT2_Q30);
			amp_v_q <= sgen_pkg::AMP_W'((pp_v_q + sgen_pkg::PP_W'(1 << 29)) >> 30);
			amp_c_q <= sgen_pkg::AMP_W'((pp_c_q + sgen_pkg::PP_W'(1 << 29)) >> 30);
		end
	end

	always_comb begin
		unique case (reg_idx)
			sgen_pkg::REG_PHASE_STEP:   prdata = phase_step_q;
			sgen_pkg::REG_PHASE_OFFSET: prdata = 32'(phase_offset_q);
			sgen_pkg::REG_VOLTAGE_RMS:  prdata = 32'(voltage_rms_q);
			sgen_pkg::REG_CURRENT_RMS:  prdata = 32'(current_rms_q);
			sgen_pkg::REG_TICK_DIVIDE:  prdata = 32'(tick_divide_q);
			default:                    prdata = '0;
		endcase
	end

	assign cfg.phase_step   = phase_step_q;
	assign cfg.phase_offset = phase_offset_q;
	assign cfg.voltage_amp  = amp_v_q;
	assign cfg.current_amp  = amp_c_q;
	assign cfg.tick_divide  = tick_divide_q;

endmodule

>>> rtl/sgen_cos_rom.sv
// ----------------------------------------------------------------------------
// sgen_cos_rom
// Two-port cosine ROM, signed Q2.30, registered read.
// ----------------------------------------------------------------------------
module sgen_cos_rom (
	input  logic                          clk,
	input  logic                          rd_en,
	input  logic [sgen_pkg::COS_AW-1:0]   addr_a,
	input  logic [sgen_pkg::COS_AW-1:0]   addr_b,
	output logic signed [31:0]            data_a,
	output logic signed [31:0]            data_b
);

	localparam sgen_pkg::cos_rom_t COS_ROM = sgen_pkg::build_cos_rom();

	always_ff @(posedge clk) begin
		if (rd_en) begin
			data_a <= COS_ROM[addr_a];
			data_b <= COS_ROM[addr_b];
		end
	end

endmodule

>>> rtl/sgen_window.sv
// ----------------------------------------------------------------------------
// sgen_window
// Sample window memory: voltage and current side by side, one write port,
// one registered read port.
// ----------------------------------------------------------------------------
module sgen_window (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [sgen_pkg::WIN_AW-1:0]   wr_addr,
	input  sgen_pkg::win_word_t           wr_data,
	input  logic                          rd_en,
	input  logic [sgen_pkg::WIN_AW-1:0]   rd_addr,
	output sgen_pkg::win_word_t           rd_data
);

	sgen_pkg::win_word_t mem [sgen_pkg::WINDOW_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/two_channel_sine_sample_generator.sv
// ----------------------------------------------------------------------------
// two_channel_sine_sample_generator
// Tick-driven voltage/current sine generator with sample windows.
// ----------------------------------------------------------------------------
// Every accepted transfer passes a four-stage pipeline (accept, table and
// window read, scale multiply, round and window write). Its result, if any,
// moves through stages 1 to 3 and the output register to the response port.
// Ticks are taken one per cycle while no stalled response holds the pipeline.
// A tick that does not hit the divider gives no result. A read is held off
// while emitted samples are still in stages 1 to 3 on their way to the window
// memory, which takes longer while responses stall. Entries never written read
// as zero: a fill count tracks them, so there is no clearing pass after reset.
// Amplitude registers follow an RMS write through a product register.
// ----------------------------------------------------------------------------
module two_channel_sine_sample_generator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sgen_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  sgen_pkg::req_t                req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output sgen_pkg::rsp_t                rsp
);

	localparam int WIN_AW = sgen_pkg::WIN_AW;
	localparam int FILL_W = sgen_pkg::FILL_W;
	localparam int COS_AW = sgen_pkg::COS_AW;
	localparam int SUM_W  = sgen_pkg::SUM_W;
	localparam int DIV_W  = sgen_pkg::DIV_W;
	localparam int MAG_W  = sgen_pkg::MAG_W;
	localparam int PROD_W = sgen_pkg::PROD_W;

	sgen_pkg::cfg_t cfg;

	// state
	logic [sgen_pkg::TICK_W-1:0] tick_cnt_q;
	logic [31:0]                 phase_q;
	logic [WIN_AW-1:0]           wp_q;
	logic [FILL_W-1:0]           fill_q;

	// handshake and stage control
	logic accept;
	logic emit;
	logic hazard;
	logic adv1;
	logic adv2;
	logic adv3;
	logic adv_o;
	logic [DIV_W-1:0] div_eff;
	logic [31:0]      phase_next;
	logic [SUM_W-1:0] pos_sum;
	logic [WIN_AW-1:0] pos;

	// stage 1
	logic              v_s1;
	logic              kind_s1;
	logic [31:0]       phase_s1;
	logic [WIN_AW-1:0] addr_s1;
	logic              wr_s1;
	logic [31:0]       phase_c;

	// stage 2
	logic              v_s2;
	logic              kind_s2;
	logic [WIN_AW-1:0] addr_s2;
	logic              wr_s2;
	logic signed [31:0] cos_v;
	logic signed [31:0] cos_c;
	sgen_pkg::win_word_t win_rd;
	logic [MAG_W-1:0]  mag_v;
	logic [MAG_W-1:0]  mag_c;

	// stage 3
	logic              v_s3;
	logic              kind_s3;
	logic [WIN_AW-1:0] addr_s3;
	logic [PROD_W-1:0] prod_v_s3;
	logic [PROD_W-1:0] prod_c_s3;
	logic              neg_v_s3;
	logic              neg_c_s3;
	sgen_pkg::win_word_t rd_s3;
	logic [PROD_W:0]   rnd_v;
	logic [PROD_W:0]   rnd_c;
	logic [31:0]       smp_v;
	logic [31:0]       smp_c;
	sgen_pkg::win_word_t wr_word;
	logic              win_we;

	// output
	logic           rsp_valid_q;
	sgen_pkg::rsp_t rsp_q;

	sgen_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// stage advance, back to front
	assign adv_o  = !rsp_valid_q || rsp_ready;
	assign adv3   = !v_s3 || adv_o;
	assign adv2   = !v_s2 || adv3;
	assign adv1   = !v_s1 || adv2;
	assign hazard = (v_s1 && (kind_s1 == sgen_pkg::KIND_SAMPLE))
		|| (v_s2 && (kind_s2 == sgen_pkg::KIND_SAMPLE))
		|| (v_s3 && (kind_s3 == sgen_pkg::KIND_SAMPLE));
	assign req_ready = adv1 && !((req.opcode == sgen_pkg::OP_READ) && hazard);
	assign accept    = req_valid && req_ready;

	always_comb begin
		if (cfg.tick_divide == '0) begin
			div_eff = DIV_W'(1);
		end else if (cfg.tick_divide > DIV_W'(sgen_pkg::DIV_MAX)) begin
			div_eff = DIV_W'(sgen_pkg::DIV_MAX);
		end else begin
			div_eff = cfg.tick_divide;
		end
	end

	assign emit       = (req.opcode == sgen_pkg::OP_TICK)
		&& ((DIV_W'(tick_cnt_q) + DIV_W'(1)) >= div_eff);
	assign phase_next = phase_q + cfg.phase_step;
	assign pos_sum    = SUM_W'(wp_q) + SUM_W'(req.read_index);
	assign pos        = pos_sum[WIN_AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_cnt_q <= '0;
			phase_q    <= '0;
			wp_q       <= '0;
			fill_q     <= '0;
		end else if (accept && (req.opcode == sgen_pkg::OP_TICK)) begin
			if (emit) begin
				tick_cnt_q <= '0;
				phase_q    <= phase_next;
				wp_q       <= wp_q + WIN_AW'(1);
				if (fill_q != FILL_W'(sgen_pkg::WINDOW_DEPTH)) begin
					fill_q <= fill_q + FILL_W'(1);
				end
			end else begin
				tick_cnt_q <= tick_cnt_q + 8'd1;
			end
		end
	end

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= accept && ((req.opcode == sgen_pkg::OP_READ) || emit);
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			kind_s1  <= (req.opcode == sgen_pkg::OP_READ) ? sgen_pkg::KIND_READ
				: sgen_pkg::KIND_SAMPLE;
			phase_s1 <= phase_next;
			addr_s1  <= (req.opcode == sgen_pkg::OP_READ) ? pos : wp_q;
			wr_s1    <= (fill_q == FILL_W'(sgen_pkg::WINDOW_DEPTH))
				|| (FILL_W'(pos) < fill_q);
		end
	end

	assign phase_c = phase_s1 + {cfg.phase_offset, 16'd0};

	sgen_cos_rom u_cos_rom (
		.clk    (clk),
		.rd_en  (adv2),
		.addr_a (phase_s1[31 -: COS_AW]),
		.addr_b (phase_c[31 -: COS_AW]),
		.data_a (cos_v),
		.data_b (cos_c)
	);

	// stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			kind_s2 <= kind_s1;
			addr_s2 <= addr_s1;
			wr_s2   <= wr_s1;
		end
	end

	assign mag_v = cos_v[31] ? MAG_W'(-cos_v) : MAG_W'(cos_v);
	assign mag_c = cos_c[31] ? MAG_W'(-cos_c) : MAG_W'(cos_c);

	// stage 3
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			kind_s3   <= kind_s2;
			addr_s3   <= addr_s2;
			prod_v_s3 <= PROD_W'(cfg.voltage_amp) * PROD_W'(mag_v);
			prod_c_s3 <= PROD_W'(cfg.current_amp) * PROD_W'(mag_c);
			neg_v_s3  <= cos_v[31];
			neg_c_s3  <= cos_c[31];
			rd_s3     <= wr_s2 ? win_rd : '0;
		end
	end

	assign rnd_v = (PROD_W + 1)'(prod_v_s3) + (PROD_W + 1)'(1 << 29);
	assign rnd_c = (PROD_W + 1)'(prod_c_s3) + (PROD_W + 1)'(1 << 29);
	assign smp_v = neg_v_s3 ? (32'd0 - 32'(rnd_v >> 30)) : 32'(rnd_v >> 30);
	assign smp_c = neg_c_s3 ? (32'd0 - 32'(rnd_c >> 30)) : 32'(rnd_c >> 30);

	assign win_we          = adv_o && v_s3 && (kind_s3 == sgen_pkg::KIND_SAMPLE);
	assign wr_word.voltage = smp_v;
	assign wr_word.current = smp_c;

	sgen_window u_window (
		.clk     (clk),
		.wr_en   (win_we),
		.wr_addr (addr_s3),
		.wr_data (wr_word),
		.rd_en   (adv2),
		.rd_addr (addr_s1),
		.rd_data (win_rd)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv_o) begin
			rsp_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_o) begin
			rsp_q.result_kind    <= kind_s3;
			rsp_q.voltage_sample <= (kind_s3 == sgen_pkg::KIND_READ) ? rd_s3.voltage : smp_v;
			rsp_q.current_sample <= (kind_s3 == sgen_pkg::KIND_READ) ? rd_s3.current : smp_c;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// write pointer tracks the fill count until the window has wrapped
	a_wp_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != FILL_W'(sgen_pkg::WINDOW_DEPTH)) |-> (wp_q == fill_q[WIN_AW-1:0]))
		else $error("write pointer and fill count disagree");

	// a result only leaves stage 3
	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(v_s3))
		else $error("result without a stage 3 entry");

	// a read never overtakes a sample still on its way to the window
	a_rd_order: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && (kind_s1 == sgen_pkg::KIND_READ)) |->
		!(v_s2 && (kind_s2 == sgen_pkg::KIND_SAMPLE))
		&& !(v_s3 && (kind_s3 == sgen_pkg::KIND_SAMPLE)))
		else $error("window read ahead of pending write");

endmodule
